@@ design/prb_pkg.sv @@
`timescale 1ns / 1ps

package prb_pkg;

   // result status codes
   localparam logic [2:0] ST_RELEASED  = 3'd0;
   localparam logic [2:0] ST_BUFFERED  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_STALE     = 3'd3;
   localparam logic [2:0] ST_IGNORED   = 3'd4;
   localparam logic [2:0] ST_OUTWIN    = 3'd5;
   localparam logic [2:0] ST_QUERY     = 3'd6;

   // request action codes
   localparam logic ACT_ADD   = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // longest release run (arriving packet plus buffered ones)
   localparam int MAX_RUN = 16;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_SEND,
      S_READ
   } state_type;

   typedef struct packed {
      logic        action;
      logic [31:0] packet_id;
      logic [15:0] payload_handle;
      logic [15:0] length;
      logic [31:0] receive_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_id;
      logic [15:0] out_handle;
      logic [15:0] out_length;
      logic [31:0] out_time;
      logic        last;
      logic        is_queued;
      logic [31:0] highest_id;
      logic [31:0] accepted_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic idle;
      logic capture;
      logic eval;
      logic load;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic pend_last;
   } sts_type;

endpackage

@@ design/prb_ram.sv @@
`timescale 1ns / 1ps

module prb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/prb_ctrl.sv @@
`timescale 1ns / 1ps

module prb_ctrl import prb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_SEND;
         end
         S_SEND: begin
            if (sts.out_free) state_in = sts.pend_last ? S_IDLE : S_READ;
         end
         S_READ: begin
            state_in = S_SEND;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle    = 1'b1;
            cmd.capture = req_valid;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
         end
         S_SEND: begin
            cmd.load = sts.out_free;
         end
         S_READ: begin
            cmd.step = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/prb_datapath.sv @@
`timescale 1ns / 1ps

module prb_datapath import prb_pkg::*; #(
   parameter int WINDOW = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   output sts_type sts,
   input  req_type req_word,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_word
);

   localparam int SPAN = (WINDOW < MAX_RUN) ? WINDOW : MAX_RUN;
   localparam int SW   = $clog2(WINDOW);
   localparam int OW   = $clog2(SPAN);
   localparam int PW   = 64;

   // (base + step) mod WINDOW, both operands below WINDOW
   function automatic logic [SW-1:0] wrap_slot(input logic [SW-1:0] base,
                                                input logic [OW-1:0] step);
      logic [SW:0] sum;
      sum = {1'b0, base} + (SW+1)'(step);
      if (sum >= (SW+1)'(WINDOW)) sum = sum - (SW+1)'(WINDOW);
      return sum[SW-1:0];
   endfunction

   // state
   req_type           item_ff, item_in;
   logic [31:0]       ne_ff, ne_in;
   logic [SW-1:0]     ns_ff, ns_in;
   logic [31:0]       count_ff, count_in;
   logic [31:0]       highest_ff, highest_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_ram_ff, pend_ram_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // classification
   logic [2*WINDOW-1:0] rot;
   logic [SPAN-1:0]     rel;
   logic [32:0]         diff;
   logic                borrow;
   logic [31:0]         off_full;
   logic                in_span;
   logic [OW-1:0]       off;
   logic                is_zero;
   logic                held;
   logic [OW-1:0]       kmax;
   logic [OW-1:0]       m;
   logic                add1;
   logic [2:0]          eval_status;
   logic                do_buffer;
   logic                do_release;
   logic [31:0]         highest_calc;
   logic [SW-1:0]       buf_slot;
   logic [SW-1:0]       ns_inc;
   logic [PW-1:0]       ram_rdata;

   // valid bits relative to the next expected slot
   assign rot = {valid_ff, valid_ff} >> ns_ff;
   assign rel = rot[SPAN-1:0];

   // offset of the item id from the next expected id
   assign diff     = {1'b0, item_ff.packet_id} - {1'b0, ne_ff};
   assign borrow   = diff[32];
   assign off_full = diff[31:0];
   assign in_span  = off_full < 32'(SPAN);
   assign off      = off_full[OW-1:0];
   assign is_zero  = off_full == 32'd0;
   assign held     = !borrow && !is_zero && in_span && rel[off];

   // farthest buffered offset, zero when nothing is held
   always_comb begin
      kmax = '0;
      for (int k = 1; k < SPAN; k++) begin
         if (rel[k]) kmax = OW'(k);
      end
   end

   always_comb begin
      priority if (item_ff.action == ACT_QUERY) begin
         eval_status = ST_QUERY;
      end else if (item_ff.length == 16'd0 || item_ff.payload_handle == 16'd0) begin
         eval_status = ST_IGNORED;
      end else if (borrow) begin
         eval_status = ST_STALE;
      end else if (is_zero) begin
         eval_status = ST_RELEASED;
      end else if (held) begin
         eval_status = ST_DUPLICATE;
      end else if (!in_span) begin
         eval_status = ST_OUTWIN;
      end else begin
         eval_status = ST_BUFFERED;
      end
   end

   assign do_buffer  = eval_status == ST_BUFFERED;
   assign do_release = eval_status == ST_RELEASED;

   // highest id + 1 as it stands after the item
   assign m            = (do_buffer && off > kmax) ? off : kmax;
   assign add1         = do_release || m != '0;
   assign highest_calc = ne_ff + 32'(m) + 32'(add1);

   assign buf_slot = wrap_slot(ns_ff, off);
   assign ns_inc   = (ns_ff == SW'(WINDOW - 1)) ? '0 : ns_ff + SW'(1);

   // payload store: handle, length, time
   prb_ram #(
      .WIDTH (PW),
      .DEPTH (WINDOW)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (cmd.eval && do_buffer),
      .wr_addr (buf_slot),
      .wr_data ({item_ff.payload_handle, item_ff.length, item_ff.receive_time}),
      .rd_en   (cmd.step),
      .rd_addr (ns_ff),
      .rd_data (ram_rdata)
   );

   // next values
   always_comb begin
      item_in      = item_ff;
      ne_in        = ne_ff;
      ns_in        = ns_ff;
      count_in     = count_ff;
      highest_in   = highest_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      pend_ram_in  = pend_ram_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.capture) item_in = req_word;

      // decide the item, update state, stage the first word
      if (cmd.eval) begin
         highest_in = highest_calc;
         if (do_release || do_buffer) count_in = count_ff + 32'd1;
         if (do_release) begin
            ne_in = ne_ff + 32'd1;
            ns_in = ns_inc;
         end
         if (do_buffer) valid_in[buf_slot] = 1'b1;
         pend_in.status         = eval_status;
         pend_in.out_id         = item_ff.packet_id;
         pend_in.out_handle     = do_release ? item_ff.payload_handle : 16'd0;
         pend_in.out_length     = do_release ? item_ff.length : 16'd0;
         pend_in.out_time       = do_release ? item_ff.receive_time : 32'd0;
         pend_in.last           = do_release ? !rel[1] : 1'b1;
         pend_in.is_queued      = (item_ff.action == ACT_QUERY) && held;
         pend_in.highest_id     = '0;
         pend_in.accepted_count = '0;
         pend_ram_in            = 1'b0;
      end

      // pull the next buffered packet of a release run
      if (cmd.step) begin
         valid_in[ns_ff]   = 1'b0;
         pend_in.status    = ST_RELEASED;
         pend_in.out_id    = ne_ff;
         pend_in.last      = !rel[1];
         pend_in.is_queued = 1'b0;
         pend_ram_in       = 1'b1;
         ne_in             = ne_ff + 32'd1;
         ns_in             = ns_inc;
      end

      // output register
      if (cmd.load) begin
         rsp_in                = pend_ff;
         rsp_in.highest_id     = highest_ff;
         rsp_in.accepted_count = count_ff;
         if (pend_ram_ff) begin
            rsp_in.out_handle = ram_rdata[63:48];
            rsp_in.out_length = ram_rdata[47:32];
            rsp_in.out_time   = ram_rdata[31:0];
         end
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff        <= '0;
         ns_ff        <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ne_ff        <= ne_in;
         ns_ff        <= ns_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      highest_ff  <= highest_in;
      pend_ff     <= pend_in;
      pend_ram_ff <= pend_ram_in;
      rsp_ff      <= rsp_in;
   end

   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.pend_last = pend_ff.last;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_ff;

endmodule

@@ design/packet_reorder_buffer_unit.sv @@
`timescale 1ns / 1ps

// Channel  Ports                           Direction  Word
// -------  ------------------------------  ---------  --------
// request  req_valid, req_stall, req_word  in         req_type
// result   rsp_valid, rsp_stall, rsp_word  out        rsp_type
//
// An item passes through accept, decide and send steps when it yields one
// result; each further packet of a release run adds a slot store read and
// a send step, since the slot store has a single read port.
// Reset clears the expected id, the accepted count and all slot valid bits.
// A stalled result holds the controller in its send step; the next item is
// taken once the last word of the current one sits in the output register.

module packet_reorder_buffer_unit import prb_pkg::*; #(
   parameter int WINDOW = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   cmd_type cmd;
   sts_type sts;

   prb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   prb_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   assign req_stall = !cmd.idle;

   // only release words may be followed by more words of the same item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_RELEASED |-> rsp_word.last)
      else $error("non-release word without last");

   // queued flag appears only on query answers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_QUERY |-> !rsp_word.is_queued)
      else $error("is_queued set outside a query answer");

   // one item at a time: an accepted word closes the request channel
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in progress");

   // a released payload always carries a non-null handle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_RELEASED |-> rsp_word.out_handle != 16'd0)
      else $error("released word with null handle");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import prb_pkg::*;

   localparam int          WIN       = 16;
   localparam int unsigned SPAN      = (WIN < MAX_RUN) ? WIN : MAX_RUN;
   localparam int          N_RANDOM  = 180;
   localparam int          CYC_LIMIT = 250000;

   // resequencing predictor plus the queue of words it expects
   class reorder_scoreboard;
      logic [31:0] next_id  = '0;
      logic [31:0] accepted = '0;
      bit          slot_full [WIN];
      logic [15:0] slot_handle [WIN];
      logic [15:0] slot_length [WIN];
      logic [31:0] slot_time [WIN];
      rsp_type     pending_words [$];
      int          errors = 0;

      function bit is_held(logic [31:0] id);
         if (id <= next_id) return 1'b0;
         if (id - next_id >= SPAN) return 1'b0;
         return slot_full[id % WIN];
      endfunction

      // highest buffered id + 1, else the expected id
      function logic [31:0] top_id();
         logic [31:0] id;
         for (int k = SPAN - 1; k >= 1; k--) begin
            id = next_id + k;
            if (slot_full[id % WIN]) return id + 1;
         end
         return next_id;
      endfunction

      // work out the words one accepted request produces
      function void resequence(req_type w);
         rsp_type     r;
         rsp_type     run [$];
         logic [31:0] hi;
         int          s;
         r = '0;
         r.out_id = w.packet_id;
         r.last = 1'b1;
         if (w.action == ACT_QUERY) begin
            r.status = ST_QUERY;
            r.is_queued = is_held(w.packet_id);
            run = {run, r};
         end else if (w.length == 0 || w.payload_handle == 0) begin
            r.status = ST_IGNORED;
            run = {run, r};
         end else if (w.packet_id < next_id) begin
            r.status = ST_STALE;
            run = {run, r};
         end else if (w.packet_id == next_id) begin
            r.status = ST_RELEASED;
            r.out_handle = w.payload_handle;
            r.out_length = w.length;
            r.out_time = w.receive_time;
            r.last = 1'b0;
            run = {run, r};
            accepted++;
            next_id++;
            // drain consecutive held packets
            while (run.size() < MAX_RUN && slot_full[next_id % WIN]) begin
               s = next_id % WIN;
               slot_full[s] = 1'b0;
               r.out_id = next_id;
               r.out_handle = slot_handle[s];
               r.out_length = slot_length[s];
               r.out_time = slot_time[s];
               run = {run, r};
               next_id++;
            end
            run[run.size() - 1].last = 1'b1;
         end else if (is_held(w.packet_id)) begin
            r.status = ST_DUPLICATE;
            run = {run, r};
         end else if (w.packet_id - next_id >= SPAN) begin
            r.status = ST_OUTWIN;
            run = {run, r};
         end else begin
            s = w.packet_id % WIN;
            slot_full[s] = 1'b1;
            slot_handle[s] = w.payload_handle;
            slot_length[s] = w.length;
            slot_time[s] = w.receive_time;
            accepted++;
            r.status = ST_BUFFERED;
            run = {run, r};
         end
         hi = top_id();
         foreach (run[i]) begin
            run[i].highest_id = hi;
            run[i].accepted_count = accepted;
            pending_words = {pending_words, run[i]};
         end
      endfunction

      function void field_check(string tag, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, tag, e, a);
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type e;
         if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected word expected none actual %h", $time, got);
            return;
         end
         e = pending_words[0];
         pending_words.delete(0);
         field_check("status", 32'(e.status), 32'(got.status));
         field_check("out_id", e.out_id, got.out_id);
         field_check("out_handle", 32'(e.out_handle), 32'(got.out_handle));
         field_check("out_length", 32'(e.out_length), 32'(got.out_length));
         field_check("out_time", e.out_time, got.out_time);
         field_check("last", 32'(e.last), 32'(got.last));
         field_check("is_queued", 32'(e.is_queued), 32'(got.is_queued));
         field_check("highest_id", e.highest_id, got.highest_id);
         field_check("accepted_count", e.accepted_count, got.accepted_count);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   bit                quiet = 1'b0;
   int                cycles = 0;
   reorder_scoreboard sb = new();

   packet_reorder_buffer_unit #(.WINDOW(WIN)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check accepted words, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_word);
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 17);
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // present one word, hold it until taken, then predict
   task automatic send_word(req_type w);
      if (!quiet)
         while ($urandom_range(0, 99) < 17) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.resequence(w);
   endtask

   task automatic add_pkt(logic [31:0] id, logic [15:0] h, logic [15:0] len,
                          logic [31:0] t);
      req_type w;
      w.action = ACT_ADD;
      w.packet_id = id;
      w.payload_handle = h;
      w.length = len;
      w.receive_time = t;
      send_word(w);
   endtask

   task automatic query_pkt(logic [31:0] id);
      req_type w;
      w = '0;
      w.action = ACT_QUERY;
      w.packet_id = id;
      send_word(w);
   endtask

   initial begin
      req_type     w;
      int          p;
      int          taken;
      logic [31:0] nxt;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty adds, extremes, stale, duplicate, window edges
      add_pkt(32'd5, 16'd7, 16'd0, 32'd1);
      add_pkt(32'd5, 16'd0, 16'd9, 32'd2);
      query_pkt(32'hFFFF_FFFF);
      add_pkt(32'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      add_pkt(32'd0, 16'd3, 16'd3, 32'd3);
      add_pkt(32'd3, 16'd1, 16'd1, 32'd0);
      add_pkt(32'd4, 16'h8000, 16'h8000, 32'h8000_0000);
      query_pkt(32'd3);
      query_pkt(32'd2);
      add_pkt(32'd3, 16'd11, 16'd11, 32'd11);
      add_pkt(32'd17, 16'd12, 16'd12, 32'd12);
      add_pkt(32'd16, 16'd13, 16'd13, 32'd13);
      add_pkt(32'hFFFF_FFFF, 16'd14, 16'd14, 32'd14);
      add_pkt(32'd1, 16'd15, 16'd15, 32'd15);
      add_pkt(32'd2, 16'd16, 16'd16, 32'd16);
      // fill the whole window, then release a run of MAX_RUN words
      for (int i = 6; i <= 20; i++)
         if (i != 16) add_pkt(i, 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 65535)), $urandom);
      add_pkt(32'd5, 16'h00FF, 16'h0F0F, 32'h5555_AAAA);

      // random: mostly ids near the expected one, some noise
      taken = 0;
      while (taken < N_RANDOM) begin
         quiet = (taken >= 70 && taken < 120);
         nxt = sb.next_id;
         w.action = ACT_ADD;
         w.payload_handle = 16'($urandom_range(1, 65535));
         w.length = 16'($urandom_range(1, 65535));
         w.receive_time = $urandom;
         p = $urandom_range(0, 99);
         if (p < 30) w.packet_id = nxt;
         else if (p < 72) w.packet_id = nxt + $urandom_range(1, 15);
         else if (p < 80) w.packet_id = nxt + $urandom_range(16, 40);
         else if (p < 88) w.packet_id = nxt - $urandom_range(1, 24);
         else w.packet_id = $urandom;
         p = $urandom_range(0, 99);
         if (p < 14) begin
            w.action = ACT_QUERY;
            if ($urandom_range(0, 2) != 0) w.packet_id = nxt + $urandom_range(0, 17);
         end else if (p < 22) begin
            if ($urandom_range(0, 1)) w.length = '0;
            if ($urandom_range(0, 1)) w.payload_handle = '0;
            else w.length = '0;
         end
         send_word(w);
         if (w.action == ACT_QUERY || (w.length != 0 && w.payload_handle != 0))
            taken++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow stray words to show up
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

@@ files.f @@
design/prb_pkg.sv
design/prb_ram.sv
design/prb_ctrl.sv
design/prb_datapath.sv
design/packet_reorder_buffer_unit.sv
dv/tb.sv
